// ===== sv/mcstb_pkg.sv =====
package mcstb_pkg;

   localparam int NUM_SLOTS   = 16;
   localparam int COUNT_BITS  = 32;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LEN_W       = $clog2(NUM_SLOTS + 1);
   localparam int MODE_W      = 3;
   localparam int SLOT_FIELD_W = 4;
   localparam int PERIOD_W    = 32;
   localparam int CMP_W       = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_START      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP       = 3'd4;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_REGISTER,
      OP_UNREGISTER,
      OP_START,
      OP_STOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      logic                repeat_flag;
   } cmd_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_WALK,
      BE_FLUSH
   } be_state_type;

endpackage

// ===== sv/multi_channel_soft_timer_bank.sv =====
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req_mode, req_timer_slot, req_period, req_repeat_flag
// result  | rsp_valid | rsp_stall | rsp_fired_slot, rsp_last_fire
//
// Requests pass a 4-entry queue; the back end takes one command per cycle while idle, none during a tick walk.
// A tick walks the slot list one entry a cycle while the result path does not hold it.
// The last fire of a tick is held until the walk ends, so last_fire is known.
// A stalled result register pauses the walk only when a second fire is ready.
// Synchronous reset clears all slots and the list; no clearing pass needed.
module multi_channel_soft_timer_bank
   import mcstb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [SLOT_FIELD_W-1:0] req_timer_slot,
   input  logic [PERIOD_W-1:0]     req_period,
   input  logic                    req_repeat_flag,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SLOT_FIELD_W-1:0] rsp_fired_slot,
   output logic                    rsp_last_fire
);

   logic    queue_full;
   logic    queue_empty;
   logic    queue_push;
   logic    queue_pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   mcstb_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_timer_slot  (req_timer_slot),
      .req_period      (req_period),
      .req_repeat_flag (req_repeat_flag),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_cmd       (push_cmd)
   );

   mcstb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (push_cmd),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   mcstb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .queue_empty    (queue_empty),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_last_fire  (rsp_last_fire)
   );

endmodule

// ===== sv/mcstb_front.sv =====
module mcstb_front
   import mcstb_pkg::*;
(
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [SLOT_FIELD_W-1:0] req_timer_slot,
   input  logic [PERIOD_W-1:0]     req_period,
   input  logic                    req_repeat_flag,
   input  logic                    queue_full,
   output logic                    queue_push,
   output cmd_type                 queue_cmd
);

   logic   slot_ok;
   logic   cmd_ok;
   op_type op;

   assign slot_ok = (32'(req_timer_slot) < NUM_SLOTS);

   always_comb begin
      cmd_ok = 1'b1;
      op     = OP_TICK;
      case (req_mode)
         MODE_TICK:       op = OP_TICK;
         MODE_REGISTER:   op = OP_REGISTER;
         MODE_UNREGISTER: op = OP_UNREGISTER;
         MODE_START:      op = OP_START;
         MODE_STOP:       op = OP_STOP;
         default:         cmd_ok = 1'b0;
      endcase
      // commands to slots outside the bank are dropped; tick ignores the slot
      if (req_mode inside {[MODE_REGISTER:MODE_STOP]} && !slot_ok) begin
         cmd_ok = 1'b0;
      end
   end

   assign req_stall             = queue_full;
   assign queue_push            = req_valid && !queue_full && cmd_ok;
   assign queue_cmd.op          = op;
   assign queue_cmd.slot        = SLOT_W'(req_timer_slot);
   assign queue_cmd.period      = req_period;
   assign queue_cmd.repeat_flag = req_repeat_flag;

endmodule

// ===== sv/mcstb_queue.sv =====
module mcstb_queue
   import mcstb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/mcstb_back.sv =====
module mcstb_back
   import mcstb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 head_cmd,
   input  logic                    queue_empty,
   output logic                    queue_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SLOT_FIELD_W-1:0] rsp_fired_slot,
   output logic                    rsp_last_fire
);

   be_state_type state_ff, state_in;

   logic [PERIOD_W-1:0]   period_ff [NUM_SLOTS];
   logic [PERIOD_W-1:0]   period_in [NUM_SLOTS];
   logic [COUNT_BITS-1:0] count_ff  [NUM_SLOTS];
   logic [COUNT_BITS-1:0] count_in  [NUM_SLOTS];
   logic [SLOT_W-1:0]     order_ff  [NUM_SLOTS];
   logic [SLOT_W-1:0]     order_in  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  repeat_ff, repeat_in;
   logic [NUM_SLOTS-1:0]  enabled_ff, enabled_in;
   logic [NUM_SLOTS-1:0]  registered_ff, registered_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      idx_ff, idx_in;
   logic                  pending_v_ff, pending_v_in;
   logic [SLOT_W-1:0]     pending_slot_ff, pending_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  exec_cmd;
   logic                  tick_start;
   logic [SLOT_W-1:0]     walk_slot;
   logic                  walk_en;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  fire;
   logic                  out_free;
   logic                  walk_done;
   logic                  walk_step;
   logic                  push_mid;
   logic                  push_last;
   logic [NUM_SLOTS-1:0]  hit;
   logic                  found;
   logic [SLOT_W-1:0]     pos;

   // tick walk datapath: one listed slot per cycle, unless the result path holds the walk
   assign walk_slot = order_ff[idx_ff[SLOT_W-1:0]];
   assign walk_en   = enabled_ff[walk_slot];
   assign cnt_inc   = count_ff[walk_slot] + 1'b1;
   assign fire      = walk_en && (period_ff[walk_slot] != '0)
                      && (CMP_W'(cnt_inc) == CMP_W'(period_ff[walk_slot]));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign walk_done = (idx_ff == len_ff);

   // position of the slot in the list, for unregister
   always_comb begin
      hit   = '0;
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit[i] = (LEN_W'(i) < len_ff) && (order_ff[i] == head_cmd.slot);
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found = 1'b1;
            pos   = SLOT_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: begin
            if (!queue_empty && head_cmd.op == OP_TICK) begin
               state_in = BE_WALK;
            end
         end
         BE_WALK: begin
            if (walk_done) begin
               state_in = BE_FLUSH;
            end
         end
         BE_FLUSH: begin
            if (!pending_v_ff || out_free) begin
               state_in = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      queue_pop  = 1'b0;
      walk_step  = 1'b0;
      push_last  = 1'b0;
      case (state_ff)
         BE_IDLE: begin
            queue_pop = !queue_empty;
         end
         BE_WALK: begin
            // a new fire must first push the held one out
            walk_step = !walk_done && !(fire && pending_v_ff && !out_free);
         end
         BE_FLUSH: begin
            push_last = pending_v_ff && out_free;
         end
         default: ;
      endcase
   end

   assign exec_cmd   = queue_pop;
   assign tick_start = queue_pop && head_cmd.op == OP_TICK;
   assign push_mid   = walk_step && fire && pending_v_ff;

   // result path: the latest fire is held back until the next one or the walk end
   always_comb begin
      idx_in          = idx_ff;
      pending_v_in    = pending_v_ff;
      pending_slot_in = pending_slot_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_slot_in     = rsp_slot_ff;
      rsp_last_in     = rsp_last_ff;
      if (tick_start) begin
         idx_in = '0;
      end else if (walk_step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (push_mid || push_last) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = pending_slot_ff;
         rsp_last_in  = push_last;
      end
      if (walk_step && fire) begin
         pending_v_in    = 1'b1;
         pending_slot_in = walk_slot;
      end else if (push_last) begin
         pending_v_in = 1'b0;
      end
   end

   // slot state updates
   always_comb begin
      period_in     = period_ff;
      count_in      = count_ff;
      order_in      = order_ff;
      repeat_in     = repeat_ff;
      enabled_in    = enabled_ff;
      registered_in = registered_ff;
      len_in        = len_ff;
      if (walk_step && walk_en) begin
         count_in[walk_slot] = fire ? '0 : cnt_inc;
         if (fire && !repeat_ff[walk_slot]) begin
            enabled_in[walk_slot] = 1'b0;
         end
      end
      if (exec_cmd) begin
         case (head_cmd.op)
            OP_REGISTER: begin
               if (!registered_ff[head_cmd.slot] && len_ff < LEN_W'(NUM_SLOTS)) begin
                  period_in[head_cmd.slot]       = head_cmd.period;
                  repeat_in[head_cmd.slot]       = head_cmd.repeat_flag;
                  count_in[head_cmd.slot]        = '0;
                  registered_in[head_cmd.slot]   = 1'b1;
                  order_in[len_ff[SLOT_W-1:0]]   = head_cmd.slot;
                  len_in                         = len_ff + 1'b1;
               end
            end
            OP_UNREGISTER: begin
               if (len_ff != '0) begin
                  period_in[head_cmd.slot] = '0;
                  repeat_in[head_cmd.slot] = 1'b0;
                  count_in[head_cmd.slot]  = '0;
                  if (registered_ff[head_cmd.slot] && found) begin
                     for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                        if (SLOT_W'(i) >= pos) begin
                           order_in[i] = order_ff[i + 1];
                        end
                     end
                     len_in                       = len_ff - 1'b1;
                     registered_in[head_cmd.slot] = 1'b0;
                  end
               end
            end
            OP_START: begin
               enabled_in[head_cmd.slot] = 1'b1;
               count_in[head_cmd.slot]   = '0;
            end
            OP_STOP: begin
               enabled_in[head_cmd.slot] = 1'b0;
               count_in[head_cmd.slot]   = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BE_IDLE;
         repeat_ff     <= '0;
         enabled_ff    <= '0;
         registered_ff <= '0;
         len_ff        <= '0;
         idx_ff        <= '0;
         pending_v_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            period_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         repeat_ff     <= repeat_in;
         enabled_ff    <= enabled_in;
         registered_ff <= registered_in;
         len_ff        <= len_in;
         idx_ff        <= idx_in;
         pending_v_ff  <= pending_v_in;
         rsp_valid_ff  <= rsp_valid_in;
         period_ff     <= period_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff        <= order_in;
      pending_slot_ff <= pending_slot_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_slot = SLOT_FIELD_W'(rsp_slot_ff);
   assign rsp_last_fire  = rsp_last_ff;

endmodule
